FILE: hw/rtl/irsd_pkg.sv
// Shared widths, constants, register indexes and types for the infusion rate block.
`default_nettype none
package irsd_pkg;

    localparam int RATE_W     = 20;
    localparam int CNT_W      = 16;
    localparam int VOL_W      = 39;
    localparam int DELAY_W    = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_CNT_W  = $clog2(DELAY_W + 1);
    localparam int SUB_CNT_W  = $clog2(VOL_W + 1);

    localparam logic [DELAY_W-1:0] DELAY_NUM = DELAY_W'(112500000);
    localparam logic [CNT_W-1:0]   INTERVAL_RESET = CNT_W'(6000);

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SET_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_INC   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_RATE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_VOL  = 3'd6;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/irsd_div.sv
// Bit-serial restoring divider of the constant step numerator by the rate.
`default_nettype none
module irsd_div
    import irsd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [RATE_W-1:0]  divisor,
    output unit_stat_t              stat,
    output logic [DELAY_W-1:0]      quotient
);

    logic [DELAY_W-1:0]   num_reg;
    logic [RATE_W-1:0]    rem_reg;
    logic [RATE_W-1:0]    den_reg;
    logic [DELAY_W-1:0]   quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [RATE_W:0]      trial;
    logic                 fits;

    assign trial = {rem_reg, num_reg[DELAY_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DELAY_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= DELAY_NUM;
            rem_reg <= '0;
            den_reg <= divisor;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DELAY_W-2:0], 1'b0};
            rem_reg <= fits ? RATE_W'(trial - {1'b0, den_reg}) : trial[RATE_W-1:0];
            quo_reg <= {quo_reg[DELAY_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/irsd_vol_sub.sv
// Bit-serial subtraction of the delivered volume from the remaining volume.
`default_nettype none
module irsd_vol_sub
    import irsd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [VOL_W-1:0]   minuend,
    input  wire logic [RATE_W-1:0]  subtrahend,
    output unit_stat_t              stat,
    output logic [VOL_W-1:0]        diff,
    output logic                    exhausted
);

    logic [VOL_W-1:0]     min_reg;
    logic [VOL_W-1:0]     sub_reg;
    logic                 borrow_reg;
    logic                 nz_reg;
    logic [SUB_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic a_bit;
    logic b_bit;
    logic d_bit;
    logic borrow_next;

    assign a_bit       = min_reg[0];
    assign b_bit       = sub_reg[0];
    assign d_bit       = a_bit ^ b_bit ^ borrow_reg;
    assign borrow_next = (~a_bit & b_bit) | (~a_bit & borrow_reg) | (b_bit & borrow_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SUB_CNT_W'(VOL_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - SUB_CNT_W'(1);
                if (cnt_reg == SUB_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            min_reg    <= minuend;
            sub_reg    <= {{(VOL_W-RATE_W){1'b0}}, subtrahend};
            borrow_reg <= 1'b0;
            nz_reg     <= 1'b0;
        end else if (busy_reg) begin
            min_reg    <= {d_bit, min_reg[VOL_W-1:1]};
            sub_reg    <= {1'b0, sub_reg[VOL_W-1:1]};
            borrow_reg <= borrow_next;
            nz_reg     <= nz_reg | d_bit;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign diff      = min_reg;
    assign exhausted = borrow_reg | ~nz_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/infusion_rate_ramp_and_step_delay_top.sv
// Top level of the infusion rate ramp, volume tracking and stepper delay block.
//
// One word on the s_ channel is one 10 ms control tick; s_restart reloads the
// ramp rate, the interval counter and the remaining volume, and clears completion.
// Each tick gives exactly one word on the m_ channel with the target rate, the
// stepper delay in microseconds, the delay valid flag, the remaining volume and
// the completion flag.
// Registers are written through the cfg_ channel, which is always ready; writes
// of the start rate and total volume reach the ramp state only through a restart.
// From acceptance to m_valid, the 39-bit volume subtract runs one bit per cycle and
// sets the latency, while the 27-bit quotient of the delay divider is formed one
// bit per cycle alongside it.
// One tick is in work at a time; s_ready is high only while no tick is in work,
// so a new tick is taken only once the last one has finished.
// A finished word waits in the output register while the next tick is taken and
// worked on; that tick's word is held back until m_ready takes the earlier one.
// Synchronous reset clears the registers to their reset values, the ramp state
// to zero, and leaves both channels empty.
`default_nettype none
module infusion_rate_ramp_and_step_delay_top
    import irsd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [VOL_W-1:0]     cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_restart,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [RATE_W-1:0]         m_rate_now,
    output logic [DELAY_W-1:0]        m_step_delay_us,
    output logic                      m_delay_valid,
    output logic [VOL_W-1:0]          m_volume_left,
    output logic                      m_done_res
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              mode_reg;
    logic [RATE_W-1:0] set_rate_reg;
    logic [RATE_W-1:0] start_rate_reg;
    logic [RATE_W-1:0] ramp_inc_reg;
    logic [RATE_W-1:0] final_rate_reg;
    logic [CNT_W-1:0]  interval_reg;
    logic [VOL_W-1:0]  total_vol_reg;

    logic [RATE_W-1:0] rate_level_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [VOL_W-1:0]  remaining_reg;
    logic              finished_reg;

    logic              state_reg;
    logic [RATE_W-1:0] rate_reg;
    logic              div_seen_reg;
    logic              sub_seen_reg;

    logic              m_valid_reg;
    logic [RATE_W-1:0] out_rate_reg;
    logic [DELAY_W-1:0] out_delay_reg;
    logic              out_dvalid_reg;
    logic [VOL_W-1:0]  out_vol_reg;
    logic              out_done_reg;

    logic              in_acc;
    logic [RATE_W-1:0] rl_base;
    logic [CNT_W-1:0]  cnt_base;
    logic [VOL_W-1:0]  rem_base;
    logic              fin_base;
    logic [CNT_W:0]    cnt_inc;
    logic              step_now;
    logic [RATE_W:0]   rate_sum;
    logic [RATE_W-1:0] rl_next;
    logic [CNT_W-1:0]  cnt_next;
    logic [RATE_W-1:0] rate_next;

    unit_stat_t        div_stat;
    unit_stat_t        sub_stat;
    logic [DELAY_W-1:0] quotient;
    logic [VOL_W-1:0]  vol_diff;
    logic              vol_exhausted;
    logic              units_done;
    logic              out_free;
    logic              finish;
    logic [VOL_W-1:0]  vol_final;
    logic              fin_final;
    logic              running;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid & s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b0;
            set_rate_reg   <= '0;
            start_rate_reg <= '0;
            ramp_inc_reg   <= '0;
            final_rate_reg <= '0;
            interval_reg   <= INTERVAL_RESET;
            total_vol_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODE:       mode_reg       <= cfg_data[0];
                REG_SET_RATE:   set_rate_reg   <= cfg_data[RATE_W-1:0];
                REG_START_RATE: start_rate_reg <= cfg_data[RATE_W-1:0];
                REG_RAMP_INC:   ramp_inc_reg   <= cfg_data[RATE_W-1:0];
                REG_FINAL_RATE: final_rate_reg <= cfg_data[RATE_W-1:0];
                REG_INTERVAL:   interval_reg   <= cfg_data[CNT_W-1:0];
                REG_TOTAL_VOL:  total_vol_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        rl_base  = s_restart ? start_rate_reg : rate_level_reg;
        cnt_base = s_restart ? '0 : count_reg;
        rem_base = s_restart ? total_vol_reg : remaining_reg;
        fin_base = s_restart ? 1'b0 : finished_reg;
        cnt_inc  = {1'b0, cnt_base} + (CNT_W+1)'(1);
        step_now = cnt_inc >= {1'b0, interval_reg};
        rate_sum = {1'b0, rl_base} + {1'b0, ramp_inc_reg};
        if (!mode_reg) begin
            rl_next  = rl_base;
            cnt_next = cnt_base;
        end else if (step_now) begin
            rl_next  = (rate_sum > {1'b0, final_rate_reg}) ? final_rate_reg
                                                           : rate_sum[RATE_W-1:0];
            cnt_next = '0;
        end else begin
            rl_next  = rl_base;
            cnt_next = cnt_inc[CNT_W-1:0];
        end
        rate_next = mode_reg ? rl_next : set_rate_reg;
    end

    irsd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_acc),
        .divisor  (rate_next),
        .stat     (div_stat),
        .quotient (quotient)
    );

    irsd_vol_sub u_vol_sub (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (in_acc),
        .minuend    (rem_base),
        .subtrahend (rl_next),
        .stat       (sub_stat),
        .diff       (vol_diff),
        .exhausted  (vol_exhausted)
    );

    assign units_done = (div_seen_reg | div_stat.done) & (sub_seen_reg | sub_stat.done);
    assign out_free   = ~m_valid_reg | m_ready;
    assign finish     = (state_reg == ST_RUN) & units_done & out_free;

    always_comb begin
        if (mode_reg) begin
            vol_final = vol_exhausted ? '0 : vol_diff;
            fin_final = finished_reg | vol_exhausted;
            running   = ~fin_final;
        end else begin
            vol_final = remaining_reg;
            fin_final = finished_reg;
            running   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            div_seen_reg   <= 1'b0;
            sub_seen_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            rate_level_reg <= '0;
            count_reg      <= '0;
            remaining_reg  <= '0;
            finished_reg   <= 1'b0;
        end else begin
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        state_reg      <= ST_RUN;
                        div_seen_reg   <= 1'b0;
                        sub_seen_reg   <= 1'b0;
                        rate_level_reg <= rl_next;
                        count_reg      <= cnt_next;
                        remaining_reg  <= rem_base;
                        finished_reg   <= fin_base;
                    end
                end
                ST_RUN: begin
                    if (div_stat.done) begin
                        div_seen_reg <= 1'b1;
                    end
                    if (sub_stat.done) begin
                        sub_seen_reg <= 1'b1;
                    end
                    if (finish) begin
                        state_reg     <= ST_IDLE;
                        remaining_reg <= vol_final;
                        finished_reg  <= fin_final;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            rate_reg <= rate_next;
        end
        if (finish) begin
            out_rate_reg   <= rate_reg;
            out_dvalid_reg <= running & (rate_reg != '0);
            out_delay_reg  <= (running & (rate_reg != '0)) ? quotient : '0;
            out_vol_reg    <= vol_final;
            out_done_reg   <= fin_final;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_rate_now      = out_rate_reg;
    assign m_step_delay_us = out_delay_reg;
    assign m_delay_valid   = out_dvalid_reg;
    assign m_volume_left   = out_vol_reg;
    assign m_done_res      = out_done_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/irsd_chk.sv
// Port-level checker for the infusion rate block and its bind to the top level.
`default_nettype none
module irsd_chk
    import irsd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [VOL_W-1:0]     cfg_data,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic                 s_restart,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [RATE_W-1:0]    m_rate_now,
    input  wire logic [DELAY_W-1:0]   m_step_delay_us,
    input  wire logic                 m_delay_valid,
    input  wire logic [VOL_W-1:0]     m_volume_left,
    input  wire logic                 m_done_res
);

    logic unused_ok;
    assign unused_ok = cfg_valid ^ cfg_ready ^ (^cfg_index) ^ (^cfg_data) ^ s_restart;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rate_now)
            && $stable(m_step_delay_us) && $stable(m_volume_left))
        else $error("result word changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second tick taken while one is in work");

    a_delay_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_delay_valid |-> m_rate_now != '0 && m_step_delay_us != '0)
        else $error("valid delay with zero rate or zero delay");

    a_delay_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_delay_valid |-> m_step_delay_us == '0)
        else $error("nonzero delay while delay is invalid");

    a_done_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_volume_left == '0)
        else $error("completion flagged with volume left");

endmodule

bind infusion_rate_ramp_and_step_delay_top irsd_chk u_irsd_chk (.*);
`default_nettype wire

FILE: test/tb_infusion_rate_ramp_and_step_delay_top.sv
// Testbench for the infusion rate ramp, volume tracking and stepper delay block.
`timescale 1ns / 100ps
`default_nettype none
module tb_infusion_rate_ramp_and_step_delay_top;
    import irsd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_TICKS = 2000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [RATE_W-1:0]  rate;
        logic [DELAY_W-1:0] delay;
        logic               delay_ok;
        logic [VOL_W-1:0]   vol;
        logic               done;
    } tick_word_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VOL_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_restart;
    logic                 m_valid;
    logic                 m_ready;
    logic [RATE_W-1:0]    m_rate_now;
    logic [DELAY_W-1:0]   m_step_delay_us;
    logic                 m_delay_valid;
    logic [VOL_W-1:0]     m_volume_left;
    logic                 m_done_res;

    // Register copies and ramp state used to predict each tick.
    logic                 mode_r;
    logic [RATE_W-1:0]    set_rate_r;
    logic [RATE_W-1:0]    start_rate_r;
    logic [RATE_W-1:0]    ramp_inc_r;
    logic [RATE_W-1:0]    final_rate_r;
    logic [CNT_W-1:0]     interval_r;
    logic [VOL_W-1:0]     total_vol_r;
    logic [RATE_W-1:0]    ramp_level;
    logic [CNT_W-1:0]     tick_count;
    logic [VOL_W-1:0]     vol_left;
    logic                 infusion_done;

    tick_word_t expected_words[$];
    int  error_count = 0;
    int  cycle_count = 0;
    int  ticks_sent = 0;
    bit  send_gaps = 1'b0;
    bit  take_gaps = 1'b0;

    infusion_rate_ramp_and_step_delay_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_restart       (s_restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rate_now      (m_rate_now),
        .m_step_delay_us (m_step_delay_us),
        .m_delay_valid   (m_delay_valid),
        .m_volume_left   (m_volume_left),
        .m_done_res      (m_done_res)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[infusion_rate_ramp_and_step_delay_top] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    function automatic void predict_tick(input logic restart);
        logic [CNT_W:0]    count_next;
        logic [RATE_W:0]   level_sum;
        logic [RATE_W-1:0] rate;
        logic              running;
        tick_word_t        word;
        if (restart) begin
            ramp_level = start_rate_r;
            tick_count = '0;
            vol_left = total_vol_r;
            infusion_done = 1'b0;
        end
        if (mode_r) begin
            count_next = {1'b0, tick_count} + 1'b1;
            if (count_next >= {1'b0, interval_r}) begin
                level_sum = {1'b0, ramp_level} + {1'b0, ramp_inc_r};
                if (level_sum > {1'b0, final_rate_r}) begin
                    level_sum = {1'b0, final_rate_r};
                end
                ramp_level = level_sum[RATE_W-1:0];
                count_next = '0;
            end
            tick_count = count_next[CNT_W-1:0];
            if (vol_left <= VOL_W'(ramp_level)) begin
                vol_left = '0;
                infusion_done = 1'b1;
            end else begin
                vol_left = vol_left - VOL_W'(ramp_level);
            end
            rate = ramp_level;
            running = !infusion_done;
        end else begin
            rate = set_rate_r;
            running = 1'b1;
        end
        running = running && (rate != '0);
        word.rate = rate;
        word.delay = running ? DELAY_NUM / DELAY_W'(rate) : '0;
        word.delay_ok = running;
        word.vol = vol_left;
        word.done = infusion_done;
        expected_words.push_back(word);
    endfunction

    always @(posedge aclk) begin : result_check
        tick_word_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word, rate", 64'(m_rate_now), 64'd0);
            end else begin
                want = expected_words.pop_front();
                if (m_rate_now !== want.rate)
                    report_mismatch("rate_now", 64'(m_rate_now), 64'(want.rate));
                if (m_step_delay_us !== want.delay)
                    report_mismatch("step_delay_us", 64'(m_step_delay_us), 64'(want.delay));
                if (m_delay_valid !== want.delay_ok)
                    report_mismatch("delay_valid", 64'(m_delay_valid), 64'(want.delay_ok));
                if (m_volume_left !== want.vol)
                    report_mismatch("volume_left", 64'(m_volume_left), 64'(want.vol));
                if (m_done_res !== want.done)
                    report_mismatch("done_res", 64'(m_done_res), 64'(want.done));
            end
        end
    end

    initial begin : result_ready
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = take_gaps ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    task automatic send_tick(input logic restart);
        int unsigned gap;
        gap = send_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_tick(restart);
        ticks_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VOL_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            REG_MODE:       mode_r = value[0];
            REG_SET_RATE:   set_rate_r = value[RATE_W-1:0];
            REG_START_RATE: start_rate_r = value[RATE_W-1:0];
            REG_RAMP_INC:   ramp_inc_r = value[RATE_W-1:0];
            REG_FINAL_RATE: final_rate_r = value[RATE_W-1:0];
            REG_INTERVAL:   interval_r = value[CNT_W-1:0];
            REG_TOTAL_VOL:  total_vol_r = value;
            default: ;
        endcase
    endtask

    task automatic load_profile(input logic ramp, input logic [RATE_W-1:0] set_rate,
                                input logic [RATE_W-1:0] start_rate,
                                input logic [RATE_W-1:0] ramp_inc,
                                input logic [RATE_W-1:0] final_rate,
                                input logic [CNT_W-1:0] interval,
                                input logic [VOL_W-1:0] total_vol);
        cfg_write(REG_MODE, VOL_W'(ramp));
        cfg_write(REG_SET_RATE, VOL_W'(set_rate));
        cfg_write(REG_START_RATE, VOL_W'(start_rate));
        cfg_write(REG_RAMP_INC, VOL_W'(ramp_inc));
        cfg_write(REG_FINAL_RATE, VOL_W'(final_rate));
        cfg_write(REG_INTERVAL, VOL_W'(interval));
        cfg_write(REG_TOTAL_VOL, total_vol);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [RATE_W-1:0] rand_rate();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return RATE_W'(1000000);
            3: return RATE_W'($urandom_range(1, 100));
            default: return RATE_W'($urandom_range(0, 20'hFFFFF));
        endcase
    endfunction

    function automatic logic [VOL_W-1:0] rand_volume();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return VOL_W'({$urandom, $urandom});
            3: return VOL_W'(64'd360000000000);
            default: return VOL_W'($urandom_range(0, 32'h00FFFFFF));
        endcase
    endfunction

    task automatic test_power_on();
        send_tick(1'b0);
        send_tick(1'b1);
        wait_idle();
    endtask

    task automatic test_constant_rate();
        load_profile(1'b0, RATE_W'(1), '0, '0, '0, INTERVAL_RESET, '0);
        send_tick(1'b0);
        wait_idle();
        load_profile(1'b0, RATE_W'(1000000), '0, '0, '0, INTERVAL_RESET, '0);
        send_tick(1'b1);
        wait_idle();
        load_profile(1'b0, '1, '0, '0, '0, INTERVAL_RESET, '0);
        send_tick(1'b0);
        wait_idle();
    endtask

    task automatic test_ramp_cases();
        // Start above the ceiling, stepping on every tick, largest volume.
        load_profile(1'b1, '0, '1, '1, RATE_W'(500000), '0, '1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_idle();
        // Volume runs out after a few steps; the ramp keeps going afterwards.
        load_profile(1'b1, '0, RATE_W'(1), RATE_W'(1000000), '1, CNT_W'(2),
                     VOL_W'(5000000));
        send_tick(1'b1);
        repeat (6) send_tick(1'b0);
        wait_idle();
        // Nothing to deliver: done on the first tick, longest interval.
        load_profile(1'b1, '0, RATE_W'(1000000), '0, RATE_W'(1000000), '1, '0);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();
        // Constant mode reports the held ramp state.
        load_profile(1'b0, RATE_W'(5), '1, '1, '1, '0, '1);
        send_tick(1'b0);
        wait_idle();
    endtask

    task automatic test_random_profiles();
        int unsigned ticks;
        logic [CNT_W-1:0] interval;
        while (ticks_sent < RANDOM_TICKS) begin
            send_gaps = $urandom_range(0, 3) != 0;
            take_gaps = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 7))
                0: interval = '0;
                1: interval = '1;
                2: interval = CNT_W'($urandom_range(1000, 65535));
                default: interval = CNT_W'($urandom_range(1, 8));
            endcase
            load_profile($urandom_range(0, 3) != 0, rand_rate(), rand_rate(), rand_rate(),
                         rand_rate(), interval, rand_volume());
            ticks = $urandom_range(8, 60);
            send_tick($urandom_range(0, 7) != 0);
            repeat (ticks - 1) send_tick($urandom_range(0, 15) == 0);
            wait_idle();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_restart = 1'b0;
        mode_r = 1'b0;
        set_rate_r = '0;
        start_rate_r = '0;
        ramp_inc_r = '0;
        final_rate_r = '0;
        interval_r = INTERVAL_RESET;
        total_vol_r = '0;
        ramp_level = '0;
        tick_count = '0;
        vol_left = '0;
        infusion_done = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_power_on();
        test_constant_rate();
        test_ramp_cases();
        test_random_profiles();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("[infusion_rate_ramp_and_step_delay_top] OK");
        end else begin
            $display("[infusion_rate_ramp_and_step_delay_top] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
hw/rtl/irsd_pkg.sv
hw/rtl/irsd_div.sv
hw/rtl/irsd_vol_sub.sv
hw/rtl/infusion_rate_ramp_and_step_delay_top.sv
hw/rtl/irsd_chk.sv
test/tb_infusion_rate_ramp_and_step_delay_top.sv
